/* hdl/isdb_pkg.sv */
// Shared constants and types for the int8 squared-distance batch unit.
// Depends on nothing; isdb_lane, isdb_merge and the top level import it.
package isdb_pkg;

    // Fixed field widths of the stream and configuration beats.
    localparam int ELEM_W  = 8;
    localparam int WORD_W  = 64;
    localparam int LEN_W   = 13;
    localparam int DIST_W  = 28;
    localparam int IDX_W   = 32;
    localparam int SQ_W    = 16;
    localparam int OUT_W   = 64;

    // Defaults for the top-level parameters.
    localparam int MAX_DIM_DEF = 4096;
    localparam int LANES_DEF   = 8;

    // Vector length after reset.
    localparam int LEN_RESET = 128;

    // Largest distance the result field can carry.
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Input selector carried in tuser.
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_DB    = 1'b1;

    // Control that travels alongside one database word down the pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             first;
        logic [IDX_W-1:0] index;
    } isdb_ctrl_t;

endpackage

/* hdl/isdb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module isdb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-first registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/isdb_lane.sv */
// One distance lane: signed int8 difference, squared, registered.
// Depends on isdb_pkg.
module isdb_lane (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       keep,
    input  logic [isdb_pkg::ELEM_W-1:0] query_elem,
    input  logic [isdb_pkg::ELEM_W-1:0] db_elem,
    output logic [isdb_pkg::SQ_W-1:0]   sq
);
    import isdb_pkg::*;

    logic signed [ELEM_W:0]     diff;
    logic signed [2*ELEM_W+1:0] prod;
    logic [SQ_W-1:0]            sq_reg;
    logic [SQ_W-1:0]            sq_next;

    // Difference of two sign-extended bytes and its square; lanes past the
    // vector length contribute zero.
    always_comb begin
        diff    = $signed({query_elem[ELEM_W-1], query_elem})
                - $signed({db_elem[ELEM_W-1], db_elem});
        prod    = diff * diff;
        sq_next = keep ? prod[SQ_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

/* hdl/isdb_merge.sv */
// Merging stage: adds the lane squares in a registered tree, then folds the
// word sum into a saturating per-vector accumulator. Depends on isdb_pkg.
module isdb_merge #(
    parameter int LANES = isdb_pkg::LANES_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic [LANES-1:0][isdb_pkg::SQ_W-1:0]    sq,
    input  isdb_pkg::isdb_ctrl_t                    ctrl_in,
    output logic                                    push,
    output logic [isdb_pkg::DIST_W-1:0]             push_dist,
    output logic [isdb_pkg::IDX_W-1:0]              push_index
);
    import isdb_pkg::*;

    localparam int SUM_W = SQ_W + ((LANES > 1) ? $clog2(LANES) : 0);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    isdb_ctrl_t        ctrl_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] acc_base;
    logic [DIST_W:0]   acc_total;
    logic [DIST_W-1:0] acc_next;

    // Sum of all lane squares for one word.
    always_comb begin
        sum_next = '0;
        for (int l = 0; l < LANES; l++) begin
            sum_next = sum_next + SUM_W'(sq[l]);
        end
    end

    // The first word of a vector starts from zero; the total saturates,
    // which is the same as clamping once at the end since it only grows.
    always_comb begin
        acc_base  = ctrl_reg.first ? '0 : acc_reg;
        acc_total = (DIST_W + 1)'(acc_base) + (DIST_W + 1)'(sum_reg);
        acc_next  = acc_total[DIST_W] ? DIST_MAX : acc_total[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            acc_reg  <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
            if (ctrl_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // A result leaves on the last word of a vector.
    assign push       = en && ctrl_reg.valid && ctrl_reg.last;
    assign push_dist  = acc_next;
    assign push_index = ctrl_reg.index;

endmodule

/* hdl/int8_squared_distance_batch_unit.sv */
// Top level of the int8 squared-distance batch unit: query store, position
// tracking, lane array, merge stage and a two-entry result buffer.
// Depends on isdb_pkg, isdb_ram, isdb_lane and isdb_merge.
//
// Usage:
//   The slave stream carries one 64-bit word of packed signed int8 elements
//   per beat (s_tdata, element 0 in the low byte) and a selector in s_tuser:
//   0 loads the next word of the query vector, 1 is a database word. A
//   query beat also drops any partial database vector and restarts the
//   vector index at zero. The master stream returns one beat per database
//   vector: the saturated squared distance and the vector index.
//   vector_length is written through the cfg_valid/cfg_ready/cfg_data port
//   while the block is idle; it sets the elements per vector for both.
//   Throughput is one beat per cycle while s_tready is high. A result passes
//   the query store read, lane square and adder tree registers and then the
//   result buffer before it appears on m_tvalid.
//   Reset clears all positions, the vector index and the result buffer and
//   sets vector_length to 128; the query store keeps no reset value and
//   must be loaded before any database word is sent.
//   When the receiver stalls, up to two results wait in the output buffer
//   and input keeps flowing; s_tready drops only when both entries are full
//   and m_tready is low.
module int8_squared_distance_batch_unit #(
    parameter int MAX_DIM = isdb_pkg::MAX_DIM_DEF,
    parameter int LANES   = isdb_pkg::LANES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write: vector_length.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [isdb_pkg::LEN_W-1:0]   cfg_data,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [isdb_pkg::WORD_W-1:0]  s_tdata,   // packed_elements[63:0]
    input  logic [0:0]                   s_tuser,   // func[0]
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [isdb_pkg::OUT_W-1:0]   m_tdata    // distance[27:0], vector_index[59:28], zero[63:60]
);
    import isdb_pkg::*;

    localparam int QDEPTH    = (MAX_DIM + LANES - 1) / LANES;
    localparam int POS_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int BASE_W    = $clog2(MAX_DIM + LANES);
    localparam int CMP_W     = (BASE_W > LEN_W) ? BASE_W : LEN_W;
    localparam int LWORD_W   = LANES * ELEM_W;
    localparam int LEN_INIT  = (LEN_RESET > MAX_DIM) ? MAX_DIM : LEN_RESET;
    localparam int ENTRY_W   = DIST_W + IDX_W;

    // Configuration and position state.
    logic [BASE_W-1:0] eff_len_reg;
    logic [BASE_W-1:0] eff_len_next;
    logic [CMP_W-1:0]  cfg_ext;
    logic [POS_W-1:0]  qpos_reg, qpos_next;
    logic [BASE_W-1:0] qbase_reg, qbase_next;
    logic [POS_W-1:0]  vpos_reg, vpos_next;
    logic [BASE_W-1:0] vbase_reg, vbase_next;
    logic [IDX_W-1:0]  vcount_reg, vcount_next;

    // Input side signals.
    logic              advance;
    logic              accept;
    logic              is_query;
    logic [POS_W-1:0]  qwr_pos;
    logic [BASE_W-1:0] qwr_base;
    logic [BASE_W:0]   qwr_end;
    logic [BASE_W:0]   vend;
    logic              db_last;
    logic [LANES-1:0]  db_mask;
    isdb_ctrl_t        ctrl0;

    // Pipeline registers.
    isdb_ctrl_t        ctrl1_reg;
    isdb_ctrl_t        ctrl2_reg;
    logic [LANES-1:0]  mask1_reg;
    logic [LWORD_W-1:0] vword1_reg;
    logic [LWORD_W-1:0] qword;
    logic [LANES-1:0][SQ_W-1:0] lane_sq;

    // Merge outputs and result buffer.
    logic              push;
    logic [DIST_W-1:0] push_dist;
    logic [IDX_W-1:0]  push_index;
    logic              pop;
    logic [ENTRY_W-1:0] buf_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;

    // The pipeline moves whenever the result buffer has room for one more.
    assign advance  = (cnt_reg != 2'd2) || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;
    assign is_query = (s_tuser[0] == FUNC_QUERY);

    // Length clamp: zero acts as one, above the maximum acts as the maximum.
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0) begin
            eff_len_next = BASE_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
            eff_len_next = BASE_W'(MAX_DIM);
        end else begin
            eff_len_next = cfg_ext[BASE_W-1:0];
        end
    end

    // Query write position wraps once it has covered the vector length.
    always_comb begin
        if (qbase_reg >= eff_len_reg) begin
            qwr_pos  = '0;
            qwr_base = '0;
        end else begin
            qwr_pos  = qpos_reg;
            qwr_base = qbase_reg;
        end
        qwr_end = (BASE_W + 1)'(qwr_base) + (BASE_W + 1)'(LANES);
    end

    // Lane mask and end-of-vector test for a database word.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            db_mask[l] = ((BASE_W + 1)'(vbase_reg) + (BASE_W + 1)'(l))
                       < (BASE_W + 1)'(eff_len_reg);
        end
        vend    = (BASE_W + 1)'(vbase_reg) + (BASE_W + 1)'(LANES);
        db_last = vend >= (BASE_W + 1)'(eff_len_reg);
    end

    // Next-state of the positions and the vector count.
    always_comb begin
        qpos_next   = qpos_reg;
        qbase_next  = qbase_reg;
        vpos_next   = vpos_reg;
        vbase_next  = vbase_reg;
        vcount_next = vcount_reg;
        if (accept) begin
            if (is_query) begin
                if (qwr_end >= (BASE_W + 1)'(eff_len_reg)) begin
                    qpos_next  = '0;
                    qbase_next = '0;
                end else begin
                    qpos_next  = qwr_pos + POS_W'(1);
                    qbase_next = qwr_end[BASE_W-1:0];
                end
                vpos_next   = '0;
                vbase_next  = '0;
                vcount_next = '0;
            end else if (db_last) begin
                vpos_next   = '0;
                vbase_next  = '0;
                vcount_next = vcount_reg + IDX_W'(1);
            end else begin
                vpos_next  = vpos_reg + POS_W'(1);
                vbase_next = vend[BASE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_len_reg <= BASE_W'(LEN_INIT);
            qpos_reg    <= '0;
            qbase_reg   <= '0;
            vpos_reg    <= '0;
            vbase_reg   <= '0;
            vcount_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                eff_len_reg <= eff_len_next;
            end
            qpos_reg   <= qpos_next;
            qbase_reg  <= qbase_next;
            vpos_reg   <= vpos_next;
            vbase_reg  <= vbase_next;
            vcount_reg <= vcount_next;
        end
    end

    // Query store: written by query beats, read at the database position.
    isdb_ram #(
        .WIDTH(LWORD_W),
        .DEPTH(QDEPTH)
    ) u_query_ram (
        .aclk  (aclk),
        .we    (accept && is_query),
        .waddr (qwr_pos),
        .wdata (s_tdata[LWORD_W-1:0]),
        .re    (advance),
        .raddr (vpos_reg),
        .rdata (qword)
    );

    // Stage 1 control and database word, aligned with the store read.
    assign ctrl0 = '{valid: accept && !is_query, last: db_last,
                     first: (vpos_reg == '0), index: vcount_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else if (advance) begin
            ctrl1_reg <= ctrl0;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mask1_reg  <= db_mask;
            vword1_reg <= s_tdata[LWORD_W-1:0];
        end
    end

    // Lane array: one squared difference per element.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        isdb_lane u_lane (
            .aclk       (aclk),
            .en         (advance),
            .keep       (mask1_reg[l]),
            .query_elem (qword[l*ELEM_W +: ELEM_W]),
            .db_elem    (vword1_reg[l*ELEM_W +: ELEM_W]),
            .sq         (lane_sq[l])
        );
    end

    // Adder tree and accumulator.
    isdb_merge #(
        .LANES(LANES)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .sq         (lane_sq),
        .ctrl_in    (ctrl2_reg),
        .push       (push),
        .push_dist  (push_dist),
        .push_index (push_index)
    );

    // Two-entry result buffer between the merge stage and the master port.
    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= {push_index, push_dist};
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {(OUT_W - ENTRY_W)'(0), buf_reg[rd_ptr_reg]};

    // The buffer never holds more than two results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    // A result is only produced when the buffer can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != 2'd2) || pop)
        else $error("result pushed into a full buffer");

    // A query beat restarts the database vector.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_query) |=> (vpos_reg == '0) && (vcount_reg == '0))
        else $error("query beat did not restart the database vector");

    // The input is held back only while both buffer entries wait.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (cnt_reg == 2'd2) && !m_tready)
        else $error("input stalled without a full result buffer");

endmodule
